// File: sv/mst_pkg.sv
`default_nettype none

package mst_pkg;

    // Request codes carried in the mode field.
    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_REGISTER = 3'd1;
    localparam logic [2:0] MODE_MODIFY   = 3'd2;
    localparam logic [2:0] MODE_STOP     = 3'd3;
    localparam logic [2:0] MODE_REARM    = 3'd4;

    // Completion codes reported with every result.
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_RANGE  = 2'd2,
        STS_UNUSED = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EXEC,
        S_REPLY
    } state_t;

    // One request item.
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot_id;
        logic [31:0] timeout;
        logic        repeat_req;
    } mst_req_t;

    // One result item.
    typedef struct packed {
        status_t     status;
        logic [3:0]  slot_result;
        logic [15:0] fired_mask;
    } mst_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic sweep_step;
        logic exec;
        logic out_load;
    } mst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
    } mst_sts_t;

endpackage

`default_nettype wire

// File: sv/mst_dp.sv
`default_nettype none

module mst_dp
    import mst_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mst_cmd_t cmd,
    output mst_sts_t      sts,
    input  wire mst_req_t req_data,
    output mst_rsp_t      rsp_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mst_req_t             req_reg;
    mst_rsp_t             rsp_reg;
    logic [IDX_W-1:0]     sweep_idx_reg, sweep_idx_next;
    logic [SLOTS-1:0]     in_use_reg, in_use_next;
    logic [SLOTS-1:0]     running_reg, running_next;
    logic [SLOTS-1:0]     periodic_reg, periodic_next;
    logic [SLOTS-1:0]     mask_reg, mask_next;
    status_t              res_status_reg, res_status_next;
    logic [3:0]           res_slot_reg, res_slot_next;

    logic [COUNT_BITS-1:0] reload_mem [SLOTS];
    logic [COUNT_BITS-1:0] count_mem  [SLOTS];

    logic [IDX_W-1:0]      id_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      free_idx;
    logic                  free_found;
    logic                  id_ok;
    logic [COUNT_BITS-1:0] tmo;
    logic [COUNT_BITS-1:0] count_rd;
    logic [COUNT_BITS-1:0] reload_rd;
    logic [COUNT_BITS-1:0] dec;
    logic                  count_wr_en;
    logic [COUNT_BITS-1:0] count_wr;
    logic                  reload_wr_en;
    logic [COUNT_BITS-1:0] reload_wr;

    assign id_idx = req_reg.slot_id[IDX_W-1:0];
    assign id_ok  = ({1'b0, req_reg.slot_id} < 5'(SLOTS));
    assign tmo    = req_reg.timeout[COUNT_BITS-1:0];

    // One read address: the sweep position during a tick, the named slot otherwise.
    assign rd_idx    = cmd.sweep_step ? sweep_idx_reg : id_idx;
    assign count_rd  = count_mem[rd_idx];
    assign reload_rd = reload_mem[rd_idx];
    assign dec       = count_rd - COUNT_BITS'(1);

    assign sts.sweep_last = (sweep_idx_reg == IDX_W'(SLOTS - 1));
    assign rsp_data       = rsp_reg;

    // Lowest free slot for a register request.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!in_use_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(s);
            end
        end
    end

    // Slot table update for the tick sweep and for single-slot requests.
    always_comb
    begin
        sweep_idx_next  = sweep_idx_reg;
        in_use_next     = in_use_reg;
        running_next    = running_reg;
        periodic_next   = periodic_reg;
        mask_next       = mask_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        wr_idx          = rd_idx;
        count_wr_en     = 1'b0;
        count_wr        = dec;
        reload_wr_en    = 1'b0;
        reload_wr       = tmo;

        if (cmd.load_in)
        begin
            sweep_idx_next = '0;
            mask_next      = '0;
        end

        // One slot per cycle of a tick.
        if (cmd.sweep_step)
        begin
            sweep_idx_next = sweep_idx_reg + IDX_W'(1);
            if (in_use_reg[sweep_idx_reg] && running_reg[sweep_idx_reg])
            begin
                count_wr_en = 1'b1;
                if (dec == '0)
                begin
                    mask_next[sweep_idx_reg] = 1'b1;
                    if (periodic_reg[sweep_idx_reg])
                    begin
                        count_wr = reload_rd;
                    end
                    else
                    begin
                        running_next[sweep_idx_reg] = 1'b0;
                    end
                end
            end
        end

        // Register, modify, stop and rearm are carried out in the exec step.
        if (cmd.exec)
        begin
            res_status_next = STS_OK;
            res_slot_next   = '0;
            unique case (req_reg.mode)
                MODE_REGISTER:
                begin
                    if (free_found)
                    begin
                        res_slot_next           = 4'(free_idx);
                        wr_idx                  = free_idx;
                        in_use_next[free_idx]   = 1'b1;
                        running_next[free_idx]  = 1'b1;
                        periodic_next[free_idx] = req_reg.repeat_req;
                        count_wr_en             = 1'b1;
                        count_wr                = tmo;
                        reload_wr_en            = 1'b1;
                    end
                    else
                    begin
                        res_status_next = STS_FULL;
                    end
                end
                MODE_MODIFY, MODE_STOP, MODE_REARM:
                begin
                    res_slot_next = req_reg.slot_id;
                    if (!id_ok)
                    begin
                        res_status_next = STS_RANGE;
                    end
                    else if (!in_use_reg[id_idx])
                    begin
                        res_status_next = STS_UNUSED;
                    end
                    else if (req_reg.mode == MODE_MODIFY)
                    begin
                        running_next[id_idx]  = 1'b1;
                        periodic_next[id_idx] = req_reg.repeat_req;
                        count_wr_en           = 1'b1;
                        count_wr              = tmo;
                        reload_wr_en          = 1'b1;
                    end
                    else if (req_reg.mode == MODE_STOP)
                    begin
                        in_use_next[id_idx]   = 1'b0;
                        running_next[id_idx]  = 1'b0;
                        periodic_next[id_idx] = 1'b0;
                    end
                    else
                    begin
                        running_next[id_idx] = 1'b1;
                        count_wr_en          = 1'b1;
                        count_wr             = reload_rd;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Slot flags and sweep control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
            in_use_reg    <= '0;
            running_reg   <= '0;
            periodic_reg  <= '0;
            mask_reg      <= '0;
        end
        else
        begin
            sweep_idx_reg <= sweep_idx_next;
            in_use_reg    <= in_use_next;
            running_reg   <= running_next;
            periodic_reg  <= periodic_next;
            mask_reg      <= mask_next;
        end
    end

    // Counter and reload values; an entry is always written before its slot is used.
    always_ff @(posedge clk)
    begin
        if (count_wr_en)
        begin
            count_mem[wr_idx] <= count_wr;
        end
        if (reload_wr_en)
        begin
            reload_mem[wr_idx] <= reload_wr;
        end
    end

    // Request capture, single-slot result and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req_data;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (cmd.out_load)
        begin
            if (req_reg.mode == MODE_TICK)
            begin
                rsp_reg.status      <= STS_OK;
                rsp_reg.slot_result <= '0;
                rsp_reg.fired_mask  <= 16'(mask_reg);
            end
            else
            begin
                rsp_reg.status      <= res_status_reg;
                rsp_reg.slot_result <= res_slot_reg;
                rsp_reg.fired_mask  <= '0;
            end
        end
    end

    // A slot can only run while it is allocated.
    a_running_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg & ~in_use_reg) == '0)
        else $error("running slot that is not in use");

    // Only allocated slots can appear in the fired mask.
    a_mask_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg & ~in_use_reg) == '0)
        else $error("fired mask names a free slot");

endmodule

`default_nettype wire

// File: sv/mst_ctrl.sv
`default_nettype none

module mst_ctrl
    import mst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [2:0] mode,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output mst_cmd_t        cmd,
    input  wire mst_sts_t   sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (mode == MODE_TICK) ? S_SWEEP : S_EXEC;
                end
            end
            S_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_REPLY;
                end
            end
            S_EXEC:
            begin
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb
    begin
        cmd            = '0;
        req_stall      = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.load_in = req_valid;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_REPLY:
            begin
                cmd.out_load = !out_valid_reg || !rsp_stall;
            end
            default:
            begin
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted item starts either the sweep or the single-slot step.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_SWEEP || state_reg == S_EXEC))
        else $error("accepted item did not start work");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !rsp_stall))
        else $error("result register overwritten");

    // The sweep runs until the last slot has been visited.
    a_sweep_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && !sts.sweep_last) |=> (state_reg == S_SWEEP))
        else $error("sweep ended early");

endmodule

`default_nettype wire

// File: sv/multi_slot_software_timer_core.sv
// Sequence: a register, modify, stop or rearm item runs through the exec state, a tick
// through the sweep state, which visits one slot per cycle through the single counter table
// read port; both then wait in the reply state until the output register is free and load
// the result. A new item is not accepted until the current one has left the reply state.
// Reset: rst_n clears every slot flag, the controller and the output valid at once;
// counter and reload values are loaded when a slot is allocated, so no clearing pass is needed.
`default_nettype none

module multi_slot_software_timer_core
    import mst_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire mst_req_t req_data,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output mst_rsp_t      rsp_data
);

    mst_cmd_t cmd;
    mst_sts_t sts;

    // Sequencing of each item.
    mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .mode      (req_data.mode),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Slot table and result formatting.
    mst_dp #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire
